// ----- sv/gpmp_pkg.sv -----
package gpmp_pkg;

    // Default sizing
    localparam int DEF_MAX_DIM     = 512;
    localparam int DEF_AMOUNT_BITS = 10;

    // Fixed field widths
    localparam int BEST_W  = 28;
    localparam int DIM_REG_W = 10;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [BEST_W-1:0] BEST_MAX = {BEST_W{1'b1}};

    // Register indexes
    typedef enum logic [0:0] {
        REG_ROWS = 1'b0,
        REG_COLS = 1'b1
    } gpmp_reg_t;

    // Saturating add of two DP-width values
    function automatic logic [BEST_W-1:0] sat_add(input logic [BEST_W-1:0] a,
                                                  input logic [BEST_W-1:0] b);
        logic [BEST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[BEST_W] ? BEST_MAX : s[BEST_W-1:0];
    endfunction

endpackage

// ----- sv/grid_prefix_max_path_dp.sv -----
// Channel | Signals                                   | Direction | Transfer
// --------+-------------------------------------------+-----------+------------------------
// in      | in_valid, in_stall, amount_west/north     | to block  | valid && !stall
// out     | out_valid, out_stall, best_total          | from block| valid && !stall
// cfg     | psel, penable, pwrite, paddr, pwdata, ... | APB       | psel && penable && pwrite
//
// One grid cell per cycle unless stalled; its DP value forms in the cycle it is accepted.
// The column state rides a chain of MAX_DIM cells that advances once per transaction;
// the cell at the last active column takes the fresh entry, cell 0 feeds the next one.
// The result of the last cell is registered and shows in the cycle after acceptance.
// Input stalls only when the last cell arrives while a previous result is still held.
// Reset needs no clearing pass: the first row ignores the chain contents.
module grid_prefix_max_path_dp
    import gpmp_pkg::*;
#(
    parameter int MAX_DIM     = DEF_MAX_DIM,
    parameter int AMOUNT_BITS = DEF_AMOUNT_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [AMOUNT_BITS-1:0] amount_west,
    input  logic [AMOUNT_BITS-1:0] amount_north,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [BEST_W-1:0]      best_total,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int SUM_W  = AMOUNT_BITS + ((MAX_DIM > 1) ? $clog2(MAX_DIM) : 0);
    localparam int CELL_W = BEST_W + SUM_W;

    logic              restart;
    logic [IDX_W-1:0]  last_row;
    logic [IDX_W-1:0]  last_col;

    logic [IDX_W-1:0]  row_idx_reg, row_idx_next;
    logic [IDX_W-1:0]  col_idx_reg, col_idx_next;
    logic [SUM_W-1:0]  row_sum_reg, row_sum_next;
    logic [BEST_W-1:0] left_reg, left_next;
    logic              out_valid_reg, out_valid_next;
    logic [BEST_W-1:0] best_reg, best_next;

    logic              in_acc;
    logic              first_row;
    logic              first_col;
    logic              last_cell_col;
    logic              last_cell;
    logic [CELL_W-1:0] chain [MAX_DIM];
    logic [CELL_W-1:0] new_entry;
    logic [BEST_W-1:0] above;
    logic [SUM_W-1:0]  col_base;
    logic [SUM_W-1:0]  row_base;
    logic [BEST_W-1:0] left_base;
    logic [SUM_W-1:0]  row_sum_new;
    logic [SUM_W-1:0]  col_sum_new;
    logic [BEST_W-1:0] cand_north;
    logic [BEST_W-1:0] cand_west;
    logic [BEST_W-1:0] dp;

    gpmp_regs #(
        .MAX_DIM (MAX_DIM),
        .IDX_W   (IDX_W)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .restart  (restart),
        .last_row (last_row),
        .last_col (last_col)
    );

    // Position flags
    assign first_row     = (row_idx_reg == '0);
    assign first_col     = (col_idx_reg == '0);
    assign last_cell_col = (col_idx_reg == last_col);
    assign last_cell     = last_cell_col && (row_idx_reg == last_row);

    // Hold input only when the final cell would overwrite an untaken result
    assign in_stall = out_valid_reg && out_stall && last_cell;
    assign in_acc   = in_valid && !in_stall;

    // DP for the current cell
    assign above       = first_row ? '0 : chain[0][CELL_W-1:SUM_W];
    assign col_base    = first_row ? '0 : chain[0][SUM_W-1:0];
    assign row_base    = first_col ? '0 : row_sum_reg;
    assign left_base   = first_col ? '0 : left_reg;
    assign row_sum_new = row_base + SUM_W'(amount_west);
    assign col_sum_new = col_base + SUM_W'(amount_north);
    assign cand_north  = sat_add(above, BEST_W'(row_sum_new));
    assign cand_west   = sat_add(left_base, BEST_W'(col_sum_new));
    assign dp          = (cand_north > cand_west) ? cand_north : cand_west;
    assign new_entry   = {dp, col_sum_new};

    // Column chain
    for (genvar k = 0; k < MAX_DIM; k++)
    begin : g_cell
        logic [CELL_W-1:0] nbr;
        if (k == MAX_DIM - 1)
        begin : g_end
            assign nbr = new_entry;
        end
        else
        begin : g_mid
            assign nbr = chain[k+1];
        end
        gpmp_cell #(
            .WIDTH (CELL_W),
            .IDX_W (IDX_W),
            .POS   (k)
        ) u_cell (
            .clk       (clk),
            .shift     (in_acc),
            .last_col  (last_col),
            .new_data  (new_entry),
            .next_data (nbr),
            .data      (chain[k])
        );
    end

    // Advance position and row state
    always_comb
    begin
        row_idx_next = row_idx_reg;
        col_idx_next = col_idx_reg;
        row_sum_next = row_sum_reg;
        left_next    = left_reg;
        priority if (restart)
        begin
            row_idx_next = '0;
            col_idx_next = '0;
        end
        else if (in_acc)
        begin
            row_sum_next = row_sum_new;
            left_next    = dp;
            if (last_cell_col)
            begin
                col_idx_next = '0;
                row_idx_next = (row_idx_reg == last_row) ? '0 : row_idx_reg + IDX_W'(1);
            end
            else
            begin
                col_idx_next = col_idx_reg + IDX_W'(1);
            end
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        best_next      = best_reg;
        if (in_acc && last_cell)
        begin
            out_valid_next = 1'b1;
            best_next      = dp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_idx_reg   <= '0;
            col_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_idx_reg   <= row_idx_next;
            col_idx_reg   <= col_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_sum_reg <= row_sum_next;
        left_reg    <= left_next;
        best_reg    <= best_next;
    end

    assign out_valid  = out_valid_reg;
    assign best_total = best_reg;

`ifndef SYNTHESIS
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_idx_reg <= last_col)
        else $error("column index beyond active width");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_idx_reg <= last_row)
        else $error("row index beyond active height");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && last_cell |=> out_valid_reg && best_reg == $past(dp))
        else $error("last cell did not produce a result");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> row_idx_reg == '0 && col_idx_reg == '0)
        else $error("register write did not restart the grid");
`endif

endmodule

// ----- sv/gpmp_cell.sv -----
module gpmp_cell
    import gpmp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int IDX_W = 1,
    parameter int POS   = 0
)
(
    input  logic             clk,
    input  logic             shift,
    input  logic [IDX_W-1:0] last_col,
    input  logic [WIDTH-1:0] new_data,
    input  logic [WIDTH-1:0] next_data,
    output logic [WIDTH-1:0] data
);

    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;
    logic             is_tail;

    // This cell is the tail of the active ring when it sits at the last column
    assign is_tail = (last_col == IDX_W'(POS));

    // Take the fresh column entry at the tail, else advance from the neighbor
    always_comb
    begin
        data_next = data_reg;
        if (shift)
        begin
            data_next = is_tail ? new_data : next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- sv/gpmp_regs.sv -----
module gpmp_regs
    import gpmp_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM,
    parameter int IDX_W   = 9
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic                  restart,
    output logic [IDX_W-1:0]      last_row,
    output logic [IDX_W-1:0]      last_col
);

    logic [DIM_REG_W-1:0] rows_reg, rows_next;
    logic [DIM_REG_W-1:0] cols_reg, cols_next;
    logic [IDX_W-1:0]     last_row_reg, last_row_next;
    logic [IDX_W-1:0]     last_col_reg, last_col_next;
    logic                 wr_en;
    gpmp_reg_t            wr_sel;
    gpmp_reg_t            rd_sel;
    logic [IDX_W-1:0]     wr_last;

    // Clamp a size to 1..MAX_DIM and return it minus one
    function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_REG_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w == 32'd0)
        begin
            w = 32'd1;
        end
        else if (w > 32'(MAX_DIM))
        begin
            w = 32'(MAX_DIM);
        end
        w = w - 32'd1;
        return w[IDX_W-1:0];
    endfunction

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign wr_sel  = gpmp_reg_t'(paddr[2]);
    assign rd_sel  = gpmp_reg_t'(paddr[2]);
    assign wr_last = dim_last(pwdata[DIM_REG_W-1:0]);
    assign restart = wr_en;

    // Decode register writes
    always_comb
    begin
        rows_next     = rows_reg;
        cols_next     = cols_reg;
        last_row_next = last_row_reg;
        last_col_next = last_col_reg;
        if (wr_en)
        begin
            unique case (wr_sel)
                REG_ROWS:
                begin
                    rows_next     = pwdata[DIM_REG_W-1:0];
                    last_row_next = wr_last;
                end
                REG_COLS:
                begin
                    cols_next     = pwdata[DIM_REG_W-1:0];
                    last_col_next = wr_last;
                end
                default:
                begin
                    rows_next = rows_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg     <= DIM_REG_W'(1);
            cols_reg     <= DIM_REG_W'(1);
            last_row_reg <= '0;
            last_col_reg <= '0;
        end
        else
        begin
            rows_reg     <= rows_next;
            cols_reg     <= cols_next;
            last_row_reg <= last_row_next;
            last_col_reg <= last_col_next;
        end
    end

    // Read back the raw register values
    always_comb
    begin
        unique case (rd_sel)
            REG_ROWS: prdata = APB_DATA_W'(rows_reg);
            REG_COLS: prdata = APB_DATA_W'(cols_reg);
            default:  prdata = '0;
        endcase
    end

    assign last_row = last_row_reg;
    assign last_col = last_col_reg;

endmodule
